[rtl/core/utf8_to_utf16_converter_defines.svh]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 converter assertion macros
// Shared concurrent assertion helpers, all disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_CONVERTER_DEFINES_SVH
`define UTF8_TO_UTF16_CONVERTER_DEFINES_SVH

// Antecedent implies consequent in the same cycle
`define U2U_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define U2U_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/u2u_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 converter package
// Result types, push bundle and constants shared by the converter modules.
// ----------------------------------------------------------------------------
package u2u_pkg;

  // Result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Scalar range constants
  localparam logic [31:0] MaxScalar   = 32'h0010_FFFF;
  localparam logic [31:0] SuppBase    = 32'h0001_0000;
  localparam logic [15:0] HiSurrogate = 16'hD800;
  localparam logic [15:0] LoSurrogate = 16'hDC00;

  // One result transaction
  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        end_of_string;
    logic        truncated;
  } result_t;

  // Up to two results produced by one input byte
  typedef struct packed {
    logic        push;
    logic        two;      // second result present
    result_t     r0;
    result_t     r1;
  } push_t;

endpackage

[rtl/core/u2u_decode.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 byte decoder
// Holds the sequence state and turns one byte into zero, one or two results.
// ----------------------------------------------------------------------------
module u2u_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,     // byte is consumed this cycle
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  output u2u_pkg::push_t push_o
);

  logic [2:0]  rem_q, rem_d;
  logic [31:0] acc_q, acc_d;

  logic [3:0]  lead_n;
  logic        lead_stop;
  logic [7:0]  lead_val;
  logic        complete;
  logic [31:0] value;
  logic [31:0] diff;
  logic [19:0] off;

  // Count leading ones of a lead byte (1 to 8)
  always_comb begin
    lead_n    = 4'd1;
    lead_stop = 1'b0;
    for (int i = 1; i < 8; i++) begin
      if (!lead_stop && byte_i[7-i]) begin
        lead_n = lead_n + 4'd1;
      end else begin
        lead_stop = 1'b1;
      end
    end
    lead_val = byte_i & (8'hFF >> lead_n);
  end

  // Sequence tracking and scalar assembly
  always_comb begin
    complete = 1'b0;
    value    = '0;
    rem_d    = rem_q;
    acc_d    = acc_q;
    if (rem_q != 3'd0) begin
      acc_d = {acc_q[25:0], byte_i[5:0]};
      rem_d = rem_q - 3'd1;
      value = acc_d;
      if (rem_d == 3'd0) begin
        complete = 1'b1;
      end
    end else if (!byte_i[7]) begin
      complete = 1'b1;
      value    = {24'd0, byte_i};
    end else begin
      value = {24'd0, lead_val};
      if (lead_n == 4'd1) begin
        complete = 1'b1;                 // stray continuation byte
      end else begin
        acc_d = {24'd0, lead_val};
        rem_d = lead_n[2:0] - 3'd1;      // eight ones wraps to seven
      end
    end
    if (last_i) begin
      rem_d = '0;
      acc_d = '0;
    end
  end

  assign diff = value - u2u_pkg::SuppBase;
  assign off  = diff[19:0];

  // Result formation
  always_comb begin
    push_o = '0;
    if (complete && value <= u2u_pkg::MaxScalar) begin
      push_o.push = 1'b1;
      if (value < u2u_pkg::SuppBase) begin
        push_o.r0.code_unit  = value[15:0];
        push_o.r0.unit_valid = 1'b1;
      end else begin
        push_o.two           = 1'b1;
        push_o.r0.code_unit  = u2u_pkg::HiSurrogate | {6'd0, off[19:10]};
        push_o.r0.unit_valid = 1'b1;
        push_o.r1.code_unit  = u2u_pkg::LoSurrogate | {6'd0, off[9:0]};
        push_o.r1.unit_valid = 1'b1;
      end
    end
    if (last_i) begin
      if (!complete) begin
        push_o               = '0;
        push_o.push          = 1'b1;
        push_o.r0.end_of_string = 1'b1;
        push_o.r0.truncated  = 1'b1;
      end else if (!push_o.push) begin
        push_o.push             = 1'b1;
        push_o.r0.end_of_string = 1'b1;
      end else if (push_o.two) begin
        push_o.r1.end_of_string = 1'b1;
      end else begin
        push_o.r0.end_of_string = 1'b1;
      end
    end
    if (!valid_i) begin
      push_o.push = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      acc_q <= '0;
    end else if (valid_i) begin
      rem_q <= rem_d;
      acc_q <= acc_d;
    end
  end

endmodule

[rtl/core/u2u_outq.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 result queue
// Small queue that takes up to two results per cycle and drains one.
// ----------------------------------------------------------------------------
module u2u_outq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  u2u_pkg::push_t                 push_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output u2u_pkg::result_t               head_o,
  output logic [u2u_pkg::QCntW-1:0]      count_o
);

  u2u_pkg::result_t              mem_q [u2u_pkg::QDepth];
  logic [u2u_pkg::QPtrW-1:0]     rd_q, rd_d;
  logic [u2u_pkg::QPtrW-1:0]     wr_q, wr_d;
  logic [u2u_pkg::QPtrW-1:0]     wr_next;
  logic [u2u_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic [u2u_pkg::QCntW-1:0]     n_push;
  logic                          do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign wr_next = wr_q + u2u_pkg::QPtrW'(1);
  assign n_push  = !push_i.push ? '0 :
                   (push_i.two ? u2u_pkg::QCntW'(2) : u2u_pkg::QCntW'(1));

  // Pointer and fill count update
  always_comb begin
    rd_d  = do_pop ? rd_q + u2u_pkg::QPtrW'(1) : rd_q;
    wr_d  = wr_q + n_push[u2u_pkg::QPtrW-1:0];
    cnt_d = cnt_q + n_push - u2u_pkg::QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage writes
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_q] <= push_i.r0;
      if (push_i.two) begin
        mem_q[wr_next] <= push_i.r1;
      end
    end
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

[rtl/core/utf8_to_utf16_converter.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 converter
// Streaming transcoder from UTF-8 bytes to UTF-16 code units.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per cycle while the result queue has room for a
// pair and yields UTF-16 code units, one per cycle while the master side
// is ready. A byte is captured in an input register, decoded from there
// against the open-sequence state and its zero, one or two results are
// pushed into a four-entry result queue that feeds the master side. The
// input side sustains one byte per cycle as long as the output side
// drains; a byte that completes a supplementary scalar yields a surrogate
// pair of two code units, which is what bounds throughput on such text.
// tlast on the input marks the end of a string; the matching result
// carries tlast, and a string cut inside a sequence yields a marker with
// the truncated flag set and no code unit.
`include "utf8_to_utf16_converter_defines.svh"

module utf8_to_utf16_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tlast,   // last_byte
  // output code unit stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic [1:0]  m_axis_tuser,   // [0] unit_valid, [1] truncated
  output logic        m_axis_tlast    // end_of_string
);

  logic                          in_valid_q;
  logic [7:0]                    in_byte_q;
  logic                          in_last_q;
  logic                          advance;
  logic [u2u_pkg::QCntW-1:0]     q_count;
  u2u_pkg::push_t                push;
  u2u_pkg::result_t              head;

  // Byte moves into decode only when the queue can take a pair
  assign advance       = in_valid_q && (q_count <= u2u_pkg::QCntW'(u2u_pkg::QDepth - 2));
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  u2u_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (advance),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .push_o  (push)
  );

  u2u_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .head_o  (head),
    .count_o (q_count)
  );

  assign m_axis_tdata = head.code_unit;
  assign m_axis_tuser = {head.truncated, head.unit_valid};
  assign m_axis_tlast = head.end_of_string;

  // Checks
  `U2U_ASSERT_IMPL(a_q_bound, 1'b1, q_count <= u2u_pkg::QCntW'(u2u_pkg::QDepth), "result queue overflow")
  `U2U_ASSERT_NEXT(a_in_hold, in_valid_q && !advance, in_valid_q, "input byte lost while stalled")
  `U2U_ASSERT_IMPL(a_trunc_end, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && !m_axis_tuser[0], "truncation marker malformed")

endmodule
